@@ hdl/polygon_cell_inclusion_test_assert.svh @@
// Assertion macros shared by the polygon cell inclusion test RTL
`ifndef POLYGON_CELL_INCLUSION_TEST_ASSERT_SVH
`define POLYGON_CELL_INCLUSION_TEST_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PCIT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define PCIT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/pcit_pkg.sv @@
// Types, constants and helpers of the polygon cell inclusion test
`default_nettype none

package pcit_pkg;

    // table and grid sizes
    localparam int MAX_VERTICES = 64;
    localparam int GRID_CELLS   = 4096;

    // field widths
    localparam int VTX_W     = 32;
    localparam int CELL_W    = 12;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CNT_OUT_W = 7;
    localparam int IDX_W     = $clog2(MAX_VERTICES);
    localparam int CNT_W     = $clog2(MAX_VERTICES + 1);

    // datapath widths, coordinates in units of 1/512
    localparam int CRD_W  = 35;
    localparam int LO_W   = 17;
    localparam int MB_W   = CRD_W - LO_W;
    localparam int PROD_W = CRD_W + MB_W;
    localparam int ACC_W  = 2 * CRD_W + 1;

    localparam logic [CFG_W-1:0] CELL_WIDTH_RESET = 16'd256;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_TEST   = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_WIDTH_X = 1'b0,
        CFG_CELL_WIDTH_Y = 1'b1
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CX,
        S_CY,
        S_CYW,
        S_RD,
        S_LD,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_M4,
        S_DEC,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [VTX_W-1:0] vertex_x;
        logic signed [VTX_W-1:0] vertex_y;
        logic [CELL_W-1:0]       cell_i;
        logic [CELL_W-1:0]       cell_j;
    } t_in_req;

    typedef struct packed {
        logic                 inside_res;
        logic [CNT_OUT_W-1:0] stored_vertices;
        logic                 table_full;
    } t_out_rsp;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_ld;
        logic acc_sub;
        logic acc_shift;
    } t_mac_ctl;

    // vertex coordinate doubled into 1/512 units
    function automatic logic signed [CRD_W-1:0] dbl(input logic signed [VTX_W-1:0] v);
        return {{(CRD_W - VTX_W - 1){v[VTX_W-1]}}, v, 1'b0};
    endfunction

    // low multiplier operand slice, zero extended
    function automatic logic signed [MB_W-1:0] lo_part(input logic signed [CRD_W-1:0] v);
        return {{(MB_W - LO_W){1'b0}}, v[LO_W-1:0]};
    endfunction

    // high multiplier operand slice, signed
    function automatic logic signed [MB_W-1:0] hi_part(input logic signed [CRD_W-1:0] v);
        return v[CRD_W-1:LO_W];
    endfunction

endpackage

`default_nettype wire

@@ hdl/polygon_cell_inclusion_test.sv @@
// Top level of the polygon cell inclusion test: config registers and units
//
// Usage: a request on the input channel (i_in_valid, i_in, o_in_stall) is
// taken when i_in_valid is high and o_in_stall low. Op clear empties the
// vertex table, op append stores one vertex (dropped and flagged when the
// table holds MAX_VERTICES), op test asks whether cell (i,j) lies inside.
// Every request gives one result on o_out_valid/o_out, taken when
// i_out_stall is low. In a test each stored vertex costs one read of the
// vertex memory, and each edge that straddles the cell row four passes
// through the one shared 35x18 multiplier plus a decision step.
// One request is in work at a time; o_in_stall is high meanwhile. A result
// waiting in the output register does not block the next request; only the
// following result waits while the receiver stalls. Reset empties the table,
// sets both cell widths to 1.0 and drops any pending result. The user must
// write cell widths through i_cfg_we/i_cfg_idx/i_cfg_data only while no
// request is in work; the block itself does not enforce this.
`default_nettype none

module polygon_cell_inclusion_test
    import pcit_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire t_in_req        i_in,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output t_out_rsp            o_out,
    input  wire                 i_out_stall,
    input  wire                 i_cfg_we,
    input  wire [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]         r_cell_width_x, r_cell_width_y;
    t_mac_ctl                 w_mac_ctl;
    logic signed [CRD_W-1:0]  w_mac_a;
    logic signed [MB_W-1:0]   w_mac_b;
    logic signed [PROD_W-1:0] w_mac_prod;
    logic signed [ACC_W-1:0]  w_mac_acc;

    // cell size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_width_x <= CELL_WIDTH_RESET;
            r_cell_width_y <= CELL_WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_CELL_WIDTH_X: r_cell_width_x <= i_cfg_data;
                CFG_CELL_WIDTH_Y: r_cell_width_y <= i_cfg_data;
            endcase
        end
    end

    pcit_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in           (i_in),
        .o_in_stall     (o_in_stall),
        .o_out_valid    (o_out_valid),
        .o_out          (o_out),
        .i_out_stall    (i_out_stall),
        .i_cell_width_x (r_cell_width_x),
        .i_cell_width_y (r_cell_width_y),
        .o_mac_ctl      (w_mac_ctl),
        .o_mac_a        (w_mac_a),
        .o_mac_b        (w_mac_b),
        .i_mac_prod     (w_mac_prod),
        .i_mac_acc      (w_mac_acc)
    );

    pcit_mul_acc u_mul_acc (
        .i_clk  (i_clk),
        .i_ctl  (w_mac_ctl),
        .i_a    (w_mac_a),
        .i_b    (w_mac_b),
        .o_prod (w_mac_prod),
        .o_acc  (w_mac_acc)
    );

endmodule

`default_nettype wire

@@ hdl/pcit_mul_acc.sv @@
// Shared signed multiplier with a shift/add/subtract accumulator
`default_nettype none

module pcit_mul_acc
    import pcit_pkg::*;
(
    input  wire                     i_clk,
    input  wire t_mac_ctl           i_ctl,
    input  wire signed [CRD_W-1:0]  i_a,
    input  wire signed [MB_W-1:0]   i_b,
    output logic signed [PROD_W-1:0] o_prod,
    output logic signed [ACC_W-1:0]  o_acc
);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_ext;
    logic signed [ACC_W-1:0]  w_add;
    logic signed [ACC_W-1:0]  w_base;

    // product registered before it reaches the accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_a * i_b;
        end
    end

    // partial product aligned to its slice position
    always_comb begin
        w_ext  = {{(ACC_W - PROD_W){r_prod[PROD_W-1]}}, r_prod};
        w_add  = i_ctl.acc_shift ? (w_ext <<< LO_W) : w_ext;
        w_base = i_ctl.acc_ld ? '0 : r_acc;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en) begin
            r_acc <= i_ctl.acc_sub ? (w_base - w_add) : (w_base + w_add);
        end
    end

    assign o_prod = r_prod;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

@@ hdl/pcit_seq.sv @@
// Sequencer, vertex memory and result register of the inclusion test
`default_nettype none
`include "polygon_cell_inclusion_test_assert.svh"

module pcit_seq
    import pcit_pkg::*;
(
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    input  wire t_in_req             i_in,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output t_out_rsp                 o_out,
    input  wire                      i_out_stall,
    input  wire [CFG_W-1:0]          i_cell_width_x,
    input  wire [CFG_W-1:0]          i_cell_width_y,
    output t_mac_ctl                 o_mac_ctl,
    output logic signed [CRD_W-1:0]  o_mac_a,
    output logic signed [MB_W-1:0]   o_mac_b,
    input  wire signed [PROD_W-1:0]  i_mac_prod,
    input  wire signed [ACC_W-1:0]   i_mac_acc
);

    t_state r_state, n_state;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic              r_ovld;
    t_out_rsp          r_out;
    logic [CELL_W-1:0] r_ci, r_cj;
    logic              r_par, r_full, r_first, r_up;

    logic signed [CRD_W-1:0] r_cx, r_cy;
    logic signed [CRD_W-1:0] r_dx0, r_dy, r_dy0, r_dx;
    logic signed [VTX_W-1:0] r_ax, r_ay, r_sx, r_sy;
    logic signed [VTX_W-1:0] r_rd_x, r_rd_y;

    logic [2*VTX_W-1:0] mem [MAX_VERTICES];

    logic w_in_acc, w_room, w_slot_free, w_in_grid, w_straddle, w_cross;

    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign w_room      = r_count < CNT_W'(MAX_VERTICES);
    assign w_slot_free = !r_ovld || !i_out_stall;
    assign w_in_grid   = (int'(i_in.cell_i) < GRID_CELLS) && (int'(i_in.cell_j) < GRID_CELLS);
    assign w_straddle  = (dbl(r_ay) <= r_cy) != (dbl(r_rd_y) <= r_cy);
    assign w_cross     = r_up ? i_mac_acc[ACC_W-1]
                              : (!i_mac_acc[ACC_W-1] && (i_mac_acc != '0));

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and shared unit control
    always_comb begin
        n_state   = r_state;
        o_mac_ctl = '0;
        o_mac_a   = '0;
        o_mac_b   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in.op == OP_TEST && w_in_grid) ? S_CX : S_FIN;
                end
            end
            S_CX: begin
                o_mac_ctl.mul_en = 1'b1;
                o_mac_a = CRD_W'({r_ci, 1'b1});
                o_mac_b = MB_W'(i_cell_width_x);
                n_state = S_CY;
            end
            S_CY: begin
                o_mac_ctl.mul_en = 1'b1;
                o_mac_a = CRD_W'({r_cj, 1'b1});
                o_mac_b = MB_W'(i_cell_width_y);
                n_state = S_CYW;
            end
            S_CYW: n_state = S_RD;
            S_RD:  n_state = (r_idx < r_count) ? S_LD : S_FIN;
            S_LD: begin
                n_state = (!r_first && w_straddle) ? S_M0 : S_RD;
            end
            // lhs - rhs = dx0*dy - dy0*dx, slice by slice
            S_M0: begin
                o_mac_ctl.mul_en = 1'b1;
                o_mac_a = r_dx0;
                o_mac_b = lo_part(r_dy);
                n_state = S_M1;
            end
            S_M1: begin
                o_mac_ctl = '{mul_en: 1'b1, acc_en: 1'b1, acc_ld: 1'b1,
                              acc_sub: 1'b0, acc_shift: 1'b0};
                o_mac_a = r_dx0;
                o_mac_b = hi_part(r_dy);
                n_state = S_M2;
            end
            S_M2: begin
                o_mac_ctl = '{mul_en: 1'b1, acc_en: 1'b1, acc_ld: 1'b0,
                              acc_sub: 1'b0, acc_shift: 1'b1};
                o_mac_a = r_dy0;
                o_mac_b = lo_part(r_dx);
                n_state = S_M3;
            end
            S_M3: begin
                o_mac_ctl = '{mul_en: 1'b1, acc_en: 1'b1, acc_ld: 1'b0,
                              acc_sub: 1'b1, acc_shift: 1'b0};
                o_mac_a = r_dy0;
                o_mac_b = hi_part(r_dx);
                n_state = S_M4;
            end
            S_M4: begin
                o_mac_ctl = '{mul_en: 1'b0, acc_en: 1'b1, acc_ld: 1'b0,
                              acc_sub: 1'b1, acc_shift: 1'b1};
                n_state = S_DEC;
            end
            S_DEC: n_state = S_RD;
            S_FIN: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // vertex count and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovld  <= 1'b0;
        end else begin
            if (w_in_acc) begin
                unique case (i_in.op)
                    OP_CLEAR:  r_count <= '0;
                    OP_APPEND: if (w_room) r_count <= r_count + 1'b1;
                    default: ;
                endcase
            end
            if (r_state == S_FIN && w_slot_free) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    // vertex memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.op == OP_APPEND && w_room) begin
            mem[r_count[IDX_W-1:0]] <= {i_in.vertex_x, i_in.vertex_y};
        end
        if (r_state == S_RD) begin
            {r_rd_x, r_rd_y} <= mem[r_idx[IDX_W-1:0]];
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_ci    <= i_in.cell_i;
            r_cj    <= i_in.cell_j;
            r_par   <= 1'b0;
            r_full  <= (i_in.op == OP_APPEND) && !w_room;
            r_idx   <= '0;
            r_first <= 1'b1;
        end
        if (r_state == S_CY) begin
            r_cx <= i_mac_prod[CRD_W-1:0];
        end
        if (r_state == S_CYW) begin
            r_cy <= i_mac_prod[CRD_W-1:0];
        end
        if (r_state == S_LD) begin
            r_idx <= r_idx + 1'b1;
            r_ax  <= r_rd_x;
            r_ay  <= r_rd_y;
            if (r_first) begin
                // first vertex of a ring: no edge yet
                r_sx    <= r_rd_x;
                r_sy    <= r_rd_y;
                r_first <= 1'b0;
            end else begin
                r_dx0   <= r_cx - dbl(r_ax);
                r_dy0   <= r_cy - dbl(r_ay);
                r_dx    <= dbl(r_rd_x) - dbl(r_ax);
                r_dy    <= dbl(r_rd_y) - dbl(r_ay);
                r_up    <= r_rd_y > r_ay;
                // ring closes when its start vertex comes back
                r_first <= (r_rd_x == r_sx) && (r_rd_y == r_sy);
            end
        end
        if (r_state == S_DEC) begin
            r_par <= r_par ^ w_cross;
        end
        if (r_state == S_FIN && w_slot_free) begin
            r_out.inside_res      <= r_par;
            r_out.stored_vertices <= CNT_OUT_W'(r_count);
            r_out.table_full      <= r_full;
        end
    end

    `PCIT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1,
                     r_count <= CNT_W'(MAX_VERTICES), "vertex count above table size")
    `PCIT_ASSERT_NOW(a_walk_in_range, i_clk, i_rst_n, r_state == S_LD,
                     r_idx < r_count, "vertex read beyond count")
    `PCIT_ASSERT_NEXT(a_fin_loads_out, i_clk, i_rst_n, (r_state == S_FIN) && w_slot_free,
                      r_ovld && (r_state == S_IDLE), "finished result not presented")

endmodule

`default_nettype wire
